@@ sv/pvm_pkg.sv @@
// ----------------------------------------------------------------------------
// pvm_pkg
// Shared types, codes and helpers of the PCM voice mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package pvm_pkg;

    localparam int VOICES  = 8;
    localparam int VW      = $clog2(VOICES);
    localparam int EFFECTS = 64;
    localparam int EW      = $clog2(EFFECTS);
    localparam int SAW     = 16;

    localparam logic [15:0] MUSIC_GAIN = 16'd11000;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_LOAD    = 2'd1;
    localparam logic [1:0] CMD_DEFINE  = 2'd2;
    localparam logic [1:0] CMD_TRIGGER = 2'd3;

    localparam logic [1:0] REG_MUSIC_ENABLE = 2'd0;
    localparam logic [1:0] REG_MUSIC_BASE   = 2'd1;
    localparam logic [1:0] REG_MUSIC_FRAMES = 2'd2;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [15:0]         address;
        logic signed [15:0]  left_in;
        logic signed [15:0]  right_in;
        logic [5:0]          effect_number;
        logic [16:0]         effect_frames;
        logic [15:0]         source_tag;
        logic [15:0]         loudness_q10;
        logic signed [15:0]  pan_q15;
    } item_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } result_t;

    typedef struct packed {
        logic          accept;
        logic          mus_rd;
        logic          mus_mul;
        logic          eff_rd_trig;
        logic          v_chk;
        logic          v_mul;
        logic          acc_add;
        logic          t_chk;
        logic          t_dec;
        logic          t_g1;
        logic          t_g2;
        logic          emit;
        logic [VW-1:0] voice;
    } ctl_t;

    typedef struct packed {
        logic music_on;
        logic active;
        logic go;
        logic out_free;
    } sts_t;

    function automatic logic [15:0] gain_of(input logic [31:0] n);
        logic [47:0] t;
        t = ({n, 16'b0} - {16'b0, n}) + 48'h0000_4000_0000;
        if (n == 32'd0)
            return 16'd0;
        else if (n[31])
            return 16'hFFFF;
        else
            return t[46:31];
    endfunction

endpackage

`default_nettype wire

@@ sv/pvm_ctrl.sv @@
// ----------------------------------------------------------------------------
// pvm_ctrl
// Sequencer: steps ticks and triggers through the voices one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module pvm_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_ready,
    input  wire logic [1:0]    item_cmd,
    input  wire pvm_pkg::sts_t sts,
    output pvm_pkg::ctl_t      ctl
);
    import pvm_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MRD  = 4'd1;
    localparam logic [3:0] S_MMUL = 4'd2;
    localparam logic [3:0] S_MADD = 4'd3;
    localparam logic [3:0] S_VEFF = 4'd4;
    localparam logic [3:0] S_VCHK = 4'd5;
    localparam logic [3:0] S_VMUL = 4'd6;
    localparam logic [3:0] S_VADD = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;
    localparam logic [3:0] S_TEFF = 4'd9;
    localparam logic [3:0] S_TCHK = 4'd10;
    localparam logic [3:0] S_TLEN = 4'd11;
    localparam logic [3:0] S_TDEC = 4'd12;
    localparam logic [3:0] S_TG1  = 4'd13;
    localparam logic [3:0] S_TG2  = 4'd14;

    logic [3:0]    state_reg, state_next;
    logic [VW-1:0] voice_reg, voice_next;
    logic          last;

    assign last       = (voice_reg == VW'(VOICES - 1));
    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        voice_next = voice_reg;
        ctl        = '0;
        ctl.voice  = voice_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                voice_next = '0;
                if (item_valid)
                begin
                    ctl.accept = 1'b1;
                    if (item_cmd == CMD_TICK)
                        state_next = S_MRD;
                    else if (item_cmd == CMD_TRIGGER)
                        state_next = S_TEFF;
                end
            end
            S_MRD:
            begin
                ctl.mus_rd = 1'b1;
                state_next = sts.music_on ? S_MMUL : S_VEFF;
            end
            S_MMUL:
            begin
                ctl.mus_mul = 1'b1;
                state_next  = S_MADD;
            end
            S_MADD:
            begin
                ctl.acc_add = 1'b1;
                state_next  = S_VEFF;
            end
            S_VEFF:
                state_next = S_VCHK;
            S_VCHK:
            begin
                ctl.v_chk = 1'b1;
                if (sts.active)
                    state_next = S_VMUL;
                else if (last)
                    state_next = S_OUT;
                else
                begin
                    voice_next = voice_reg + 1'b1;
                    state_next = S_VEFF;
                end
            end
            S_VMUL:
            begin
                ctl.v_mul  = 1'b1;
                state_next = S_VADD;
            end
            S_VADD:
            begin
                ctl.acc_add = 1'b1;
                if (last)
                    state_next = S_OUT;
                else
                begin
                    voice_next = voice_reg + 1'b1;
                    state_next = S_VEFF;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TEFF:
                state_next = S_TCHK;
            S_TCHK:
            begin
                ctl.t_chk = 1'b1;
                if (last)
                    state_next = S_TLEN;
                else
                begin
                    voice_next = voice_reg + 1'b1;
                    state_next = S_TEFF;
                end
            end
            S_TLEN:
            begin
                ctl.eff_rd_trig = 1'b1;
                state_next      = S_TDEC;
            end
            S_TDEC:
            begin
                ctl.t_dec  = 1'b1;
                state_next = sts.go ? S_TG1 : S_IDLE;
            end
            S_TG1:
            begin
                ctl.t_g1   = 1'b1;
                state_next = S_TG2;
            end
            S_TG2:
            begin
                ctl.t_g2   = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            voice_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            voice_reg <= voice_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/pvm_dp.sv @@
// ----------------------------------------------------------------------------
// pvm_dp
// Datapath: sample and effect memories, voice state, mix accumulator, output.
// ----------------------------------------------------------------------------
`default_nettype none

module pvm_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pvm_pkg::item_t item,
    input  wire pvm_pkg::ctl_t  ctl,
    output pvm_pkg::sts_t       sts,
    input  wire logic           cfg_write_en,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [16:0]    cfg_data,
    output logic                result_valid,
    input  wire logic           result_ready,
    output pvm_pkg::result_t    result
);
    import pvm_pkg::*;

    logic [31:0]  smem [2**SAW];
    logic [31:0]  smem_q;
    logic [32:0]  emem [EFFECTS];
    logic [32:0]  emem_q;
    logic [EFFECTS-1:0] evalid_reg;
    logic         evq_reg;
    logic [SAW-1:0] s_addr;
    logic [EW-1:0]  e_addr;
    logic [15:0]  e_start;
    logic [16:0]  e_len;

    item_t        item_reg;
    logic         music_enable_reg;
    logic [15:0]  music_base_reg;
    logic [16:0]  music_frames_reg;
    logic [15:0]  music_pos_reg;
    logic [16:0]  frames;
    logic [16:0]  mpos_inc;

    logic [VOICES-1:0] v_busy_reg;
    logic [EW-1:0] v_eff_reg [VOICES];
    logic [16:0]  v_pos_reg  [VOICES];
    logic [15:0]  v_src_reg  [VOICES];
    logic [15:0]  v_prio_reg [VOICES];
    logic [15:0]  v_gl_reg   [VOICES];
    logic [15:0]  v_gr_reg   [VOICES];

    logic signed [32:0] prod_l_reg, prod_r_reg;
    logic signed [23:0] acc_l_reg, acc_r_reg;
    logic [15:0]  gl_sel, gr_sel;
    logic signed [17:0] term_l, term_r;

    logic         t_match_reg, t_free_reg, t_weak_found_reg;
    logic [VW-1:0] t_free_idx_reg, t_weak_idx_reg, pick_reg;
    logic [15:0]  t_weak_reg;
    logic [31:0]  n_reg;
    logic [15:0]  gl_new_reg;
    logic [16:0]  pan_ext, offs;
    logic [32:0]  n_prod;

    result_t      result_reg;
    logic         result_valid_reg;

    assign frames       = (music_frames_reg > 17'h10000) ? 17'h10000 : music_frames_reg;
    assign sts.music_on = music_enable_reg && (frames != 17'd0);
    assign mpos_inc     = {1'b0, music_pos_reg} + 17'd1;

    assign e_start    = evq_reg ? emem_q[32:17] : 16'd0;
    assign e_len      = evq_reg ? emem_q[16:0]  : 17'd0;
    assign sts.active = v_busy_reg[ctl.voice] && (v_pos_reg[ctl.voice] < e_len);
    assign sts.go     = (e_len != 17'd0) && (item_reg.loudness_q10 != 16'd0) && !t_match_reg
                        && (t_free_reg || (t_weak_found_reg
                        && (item_reg.loudness_q10 > t_weak_reg)));
    assign sts.out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        if (ctl.mus_rd)
            s_addr = music_base_reg + music_pos_reg;
        else
            s_addr = e_start + v_pos_reg[ctl.voice][15:0];
        e_addr = ctl.eff_rd_trig ? item_reg.effect_number : v_eff_reg[ctl.voice];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept && item.cmd == CMD_LOAD)
            smem[item.address] <= {item.right_in, item.left_in};
        smem_q <= smem[s_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept && item.cmd == CMD_DEFINE)
            emem[item.effect_number] <= {item.address, item.effect_frames};
        emem_q <= emem[e_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evalid_reg <= '0;
            evq_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.accept && item.cmd == CMD_DEFINE)
                evalid_reg[item.effect_number] <= 1'b1;
            evq_reg <= evalid_reg[e_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            music_enable_reg <= 1'b0;
            music_base_reg   <= '0;
            music_frames_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_MUSIC_ENABLE: music_enable_reg <= cfg_data[0];
                REG_MUSIC_BASE:   music_base_reg   <= cfg_data[15:0];
                REG_MUSIC_FRAMES: music_frames_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        gl_sel = ctl.mus_mul ? MUSIC_GAIN : v_gl_reg[ctl.voice];
        gr_sel = ctl.mus_mul ? MUSIC_GAIN : v_gr_reg[ctl.voice];
        term_l = prod_l_reg[32:15];
        term_r = prod_r_reg[32:15];
        pan_ext = {item_reg.pan_q15[15], item_reg.pan_q15};
        offs    = ctl.t_dec ? (17'h08000 - pan_ext) : (17'h08000 + pan_ext);
        n_prod  = item_reg.loudness_q10 * offs;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
            item_reg <= item;
        if (ctl.mus_mul || ctl.v_mul)
        begin
            prod_l_reg <= $signed(smem_q[15:0])  * $signed({1'b0, gl_sel});
            prod_r_reg <= $signed(smem_q[31:16]) * $signed({1'b0, gr_sel});
        end
        if (ctl.accept)
        begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (ctl.acc_add)
        begin
            acc_l_reg <= acc_l_reg + {{6{term_l[17]}}, term_l};
            acc_r_reg <= acc_r_reg + {{6{term_r[17]}}, term_r};
        end
        if (ctl.t_dec)
            pick_reg <= t_free_reg ? t_free_idx_reg : t_weak_idx_reg;
        if (ctl.t_dec || ctl.t_g1)
            n_reg <= n_prod[31:0];
        if (ctl.t_g1)
            gl_new_reg <= gain_of(n_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            music_pos_reg    <= '0;
            t_match_reg      <= 1'b0;
            t_free_reg       <= 1'b0;
            t_weak_found_reg <= 1'b0;
            t_free_idx_reg   <= '0;
            t_weak_idx_reg   <= '0;
            t_weak_reg       <= 16'hFFFF;
        end
        else
        begin
            if (ctl.mus_mul)
                music_pos_reg <= (mpos_inc >= frames) ? 16'd0 : mpos_inc[15:0];
            if (ctl.accept)
            begin
                t_match_reg      <= 1'b0;
                t_free_reg       <= 1'b0;
                t_weak_found_reg <= 1'b0;
                t_weak_reg       <= 16'hFFFF;
            end
            else if (ctl.t_chk)
            begin
                if (sts.active && v_src_reg[ctl.voice] == item_reg.source_tag)
                    t_match_reg <= 1'b1;
                if (!sts.active && !t_free_reg)
                begin
                    t_free_reg     <= 1'b1;
                    t_free_idx_reg <= ctl.voice;
                end
                if (v_prio_reg[ctl.voice] < t_weak_reg)
                begin
                    t_weak_reg       <= v_prio_reg[ctl.voice];
                    t_weak_idx_reg   <= ctl.voice;
                    t_weak_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_busy_reg <= '0;
            for (int i = 0; i < VOICES; i++)
            begin
                v_eff_reg[i]  <= '0;
                v_pos_reg[i]  <= '0;
                v_src_reg[i]  <= '0;
                v_prio_reg[i] <= '0;
                v_gl_reg[i]   <= '0;
                v_gr_reg[i]   <= '0;
            end
        end
        else
        begin
            if (ctl.v_chk && !sts.active)
                v_busy_reg[ctl.voice] <= 1'b0;
            if (ctl.v_mul)
                v_pos_reg[ctl.voice] <= v_pos_reg[ctl.voice] + 17'd1;
            if (ctl.t_g2)
            begin
                v_busy_reg[pick_reg] <= 1'b1;
                v_eff_reg[pick_reg]  <= item_reg.effect_number;
                v_pos_reg[pick_reg]  <= '0;
                v_src_reg[pick_reg]  <= item_reg.source_tag;
                v_prio_reg[pick_reg] <= item_reg.loudness_q10;
                v_gl_reg[pick_reg]   <= gl_new_reg;
                v_gr_reg[pick_reg]   <= gain_of(n_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            if (acc_l_reg > 24'sd32767)
                result_reg.left_out <= 16'sh7FFF;
            else if (acc_l_reg < -24'sd32768)
                result_reg.left_out <= 16'sh8000;
            else
                result_reg.left_out <= acc_l_reg[15:0];
            if (acc_r_reg > 24'sd32767)
                result_reg.right_out <= 16'sh7FFF;
            else if (acc_r_reg < -24'sd32768)
                result_reg.right_out <= 16'sh8000;
            else
                result_reg.right_out <= acc_r_reg[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (ctl.emit)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

@@ sv/pcm_voice_mixer_with_priority_steal.sv @@
// ----------------------------------------------------------------------------
// pcm_voice_mixer_with_priority_steal
// Stereo PCM mixer with eight effect voices, priority stealing and music.
//
// Items arrive on item/item_valid/item_ready; one transfer per item. A load or
// define item finishes in the cycle of its transfer. A trigger walks all eight
// voices through the effect table, then reads the new effect's entry, decides,
// and computes the two gains only when it starts a voice. A tick reads the
// music frame when music plays, then each voice: effect read and check, and
// multiply and add when it plays, through the single sample memory read port
// and one shared multiplier pair; then it loads the result register.
// A tick's frame appears on result/result_valid; it waits there until
// result_ready. Next items are taken while it waits; a later tick holds in its
// output state until the result register is free.
// Configuration is written through cfg_write_en/cfg_index/cfg_data at once.
// Reset clears voices, effect table and registers; the sample memory holds
// whatever was loaded and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_voice_mixer_with_priority_steal (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire pvm_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output pvm_pkg::result_t      result,
    input  wire logic             cfg_write_en,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [16:0]      cfg_data
);
    import pvm_pkg::*;

    ctl_t ctl;
    sts_t sts;

    pvm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_cmd   (item.cmd),
        .sts        (sts),
        .ctl        (ctl)
    );

    pvm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .ctl          (ctl),
        .sts          (sts),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!item_ready))
        else $error("result appeared without a tick in progress");

    a_no_result_after_plain: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.cmd != CMD_TICK) |=>
        !(result_valid && !$past(result_valid)))
        else $error("non-tick item produced a result");

    a_emit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> (!result_valid || result_ready))
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire

@@ bench/tb_pcm_voice_mixer_with_priority_steal.sv @@
// ----------------------------------------------------------------------------
// tb_pcm_voice_mixer_with_priority_steal
// Self-checking bench for the stereo PCM voice mixer.
//
// A local model tracks the sample store, the effect table, the eight voices
// and the music track. Every accepted item updates it, and every tick queues
// the mixed frame it should produce. Each frame that leaves the block is
// compared with the oldest queued frame. Before a tick, the bench loads any
// store entry the tick would read that has not been written yet.
// Directed tests cover allocation, suppression, stealing, saturation,
// wrap-around and music settings. Random traffic follows under several idle
// and stall mixes, plus a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pcm_voice_mixer_with_priority_steal;

    timeunit 1ns;
    timeprecision 1ps;

    import pvm_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    item_t            item;
    logic             result_valid;
    logic             result_ready;
    result_t          result;
    logic             cfg_write_en;
    logic [1:0]       cfg_index;
    logic [16:0]      cfg_data;

    pcm_voice_mixer_with_priority_steal u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // mixer state mirror
    logic [31:0] frame_mem [0:65535];
    bit          frame_written [0:65535];
    logic [15:0] fx_start [0:EFFECTS-1];
    logic [16:0] fx_len [0:EFFECTS-1];
    bit          v_busy [0:VOICES-1];
    logic [5:0]  v_fx [0:VOICES-1];
    logic [16:0] v_pos [0:VOICES-1];
    logic [15:0] v_src [0:VOICES-1];
    logic [15:0] v_prio [0:VOICES-1];
    logic [15:0] v_gain_l [0:VOICES-1];
    logic [15:0] v_gain_r [0:VOICES-1];
    logic [15:0] mus_pos;
    logic        mus_en;
    logic [15:0] mus_base;
    logic [16:0] mus_len;

    result_t     expected_frames [$];
    logic [15:0] tick_reads [$];

    int errors;
    int frames_checked;
    int items_sent;
    int ticks_sent;
    int steals_seen;
    int snd_pct;
    int rcv_pct;
    int rcv_hold;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAIL pcm_voice_mixer_with_priority_steal");
        $finish;
    end

    function automatic int scale_q15(logic signed [15:0] s, logic [15:0] g);
        longint ps;
        longint pg;
        ps = s;
        pg = g;
        return int'((ps * pg) >>> 15);
    endfunction

    function automatic logic [15:0] pan_gain(longint n);
        if (n == 0)
            return 16'd0;
        if (n >= 64'sd2147483648)
            return 16'hFFFF;
        return 16'((n * 65535 + 64'sd1073741824) >>> 31);
    endfunction

    function automatic logic [15:0] clamp16(int v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic bit voice_playing(int i);
        return v_busy[i] && (v_pos[i] < fx_len[v_fx[i]]);
    endfunction

    function automatic void list_tick_reads();
        tick_reads.delete();
        if (mus_en && mus_len != 0)
            tick_reads.push_back(mus_base + mus_pos);
        for (int i = 0; i < VOICES; i++)
            if (voice_playing(i))
                tick_reads.push_back(fx_start[v_fx[i]] + v_pos[i][15:0]);
    endfunction

    function automatic void start_voice(item_t it);
        int     pick;
        int     weakest;
        longint lv;
        longint pv;
        pick = -1;
        weakest = 65535;
        lv = it.loudness_q10;
        pv = it.pan_q15;
        if (fx_len[it.effect_number] == 0 || it.loudness_q10 == 0)
            return;
        for (int i = 0; i < VOICES; i++)
            if (voice_playing(i) && v_src[i] == it.source_tag)
                return;
        for (int i = 0; i < VOICES; i++)
            if (pick < 0 && !voice_playing(i))
                pick = i;
        if (pick < 0)
        begin
            for (int i = 0; i < VOICES; i++)
                if (v_prio[i] < weakest)
                begin
                    weakest = v_prio[i];
                    pick = i;
                end
            if (pick < 0 || int'(it.loudness_q10) <= weakest)
                return;
            steals_seen++;
        end
        v_busy[pick] = 1'b1;
        v_fx[pick] = it.effect_number;
        v_pos[pick] = '0;
        v_src[pick] = it.source_tag;
        v_prio[pick] = it.loudness_q10;
        v_gain_l[pick] = pan_gain(lv * (32768 - pv));
        v_gain_r[pick] = pan_gain(lv * (32768 + pv));
    endfunction

    function automatic void mix_frame();
        int          l;
        int          r;
        logic [16:0] span;
        logic [31:0] w;
        result_t     res;
        l = 0;
        r = 0;
        span = (mus_len > 17'd65536) ? 17'd65536 : mus_len;
        if (mus_en && span != 0)
        begin
            w = frame_mem[16'(mus_base + mus_pos)];
            l += scale_q15(w[15:0], MUSIC_GAIN);
            r += scale_q15(w[31:16], MUSIC_GAIN);
            if ({1'b0, mus_pos} + 17'd1 >= span)
                mus_pos = '0;
            else
                mus_pos = mus_pos + 16'd1;
        end
        for (int i = 0; i < VOICES; i++)
        begin
            if (!voice_playing(i))
            begin
                v_busy[i] = 1'b0;
                continue;
            end
            w = frame_mem[16'(fx_start[v_fx[i]] + v_pos[i][15:0])];
            l += scale_q15(w[15:0], v_gain_l[i]);
            r += scale_q15(w[31:16], v_gain_r[i]);
            v_pos[i] = v_pos[i] + 17'd1;
        end
        res.left_out = clamp16(l);
        res.right_out = clamp16(r);
        expected_frames.push_back(res);
    endfunction

    function automatic void apply_item(item_t it);
        case (it.cmd)
            CMD_TICK:
            begin
                mix_frame();
                ticks_sent++;
            end
            CMD_LOAD:
            begin
                frame_mem[it.address] = {it.right_in, it.left_in};
                frame_written[it.address] = 1'b1;
            end
            CMD_DEFINE:
            begin
                fx_start[it.effect_number] = it.address;
                fx_len[it.effect_number] = it.effect_frames;
            end
            default: start_voice(it);
        endcase
        items_sent++;
    endfunction

    function automatic item_t rand_fields();
        item_t it;
        it = item_t'({$urandom, $urandom, $urandom, $urandom});
        return it;
    endfunction

    task automatic send_item(item_t it);
        @(negedge clk);
        while ($urandom_range(99) < snd_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        item = it;
        do
            @(posedge clk);
        while (!item_ready);
        apply_item(it);
    endtask

    task automatic put_item(item_t it);
        item_t ld;
        if (it.cmd == CMD_TICK)
        begin
            list_tick_reads();
            foreach (tick_reads[k])
                if (!frame_written[tick_reads[k]])
                begin
                    ld = rand_fields();
                    ld.cmd = CMD_LOAD;
                    ld.address = tick_reads[k];
                    send_item(ld);
                end
        end
        send_item(it);
    endtask

    task automatic load_frame(logic [15:0] a, logic [15:0] l, logic [15:0] r);
        item_t it;
        it = rand_fields();
        it.cmd = CMD_LOAD;
        it.address = a;
        it.left_in = l;
        it.right_in = r;
        put_item(it);
    endtask

    task automatic define_fx(logic [5:0] n, logic [15:0] a, logic [16:0] len);
        item_t it;
        it = rand_fields();
        it.cmd = CMD_DEFINE;
        it.effect_number = n;
        it.address = a;
        it.effect_frames = len;
        put_item(it);
    endtask

    task automatic trigger_fx(logic [5:0] n, logic [15:0] src, logic [15:0] loud,
                              logic [15:0] pan);
        item_t it;
        it = rand_fields();
        it.cmd = CMD_TRIGGER;
        it.effect_number = n;
        it.source_tag = src;
        it.loudness_q10 = loud;
        it.pan_q15 = pan;
        put_item(it);
    endtask

    task automatic tick_frames(int n);
        item_t it;
        for (int k = 0; k < n; k++)
        begin
            it = rand_fields();
            it.cmd = CMD_TICK;
            put_item(it);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        item_valid = 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] data);
        @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_write_en = 1'b0;
        cfg_data = 17'($urandom);
        case (idx)
            REG_MUSIC_ENABLE: mus_en = data[0];
            REG_MUSIC_BASE:   mus_base = data[15:0];
            REG_MUSIC_FRAMES: mus_len = data;
            default: ;
        endcase
    endtask

    task automatic set_music(logic [16:0] en, logic [16:0] base, logic [16:0] len);
        settle();
        write_reg(REG_MUSIC_ENABLE, en);
        write_reg(REG_MUSIC_BASE, base);
        write_reg(REG_MUSIC_FRAMES, len);
    endtask

    function automatic item_t rand_item();
        item_t it;
        int    sel;
        it = rand_fields();
        sel = $urandom_range(99);
        if (sel < 12)
        begin
            it.cmd = CMD_LOAD;
            if ($urandom_range(1))
                it.address = 16'($urandom_range(255));
        end
        else if (sel < 22)
        begin
            it.cmd = CMD_DEFINE;
            it.effect_number = 6'($urandom_range(15));
            if ($urandom_range(3) != 0)
                it.address = 16'hFFE0 + 16'($urandom_range(255));
            sel = $urandom_range(19);
            if (sel == 0)
                it.effect_frames = 17'd0;
            else if (sel == 1)
                it.effect_frames = 17'd65536;
            else if (sel == 2)
                it.effect_frames = 17'($urandom_range(65536));
            else
                it.effect_frames = 17'($urandom_range(1, 48));
        end
        else if (sel < 50)
        begin
            it.cmd = CMD_TRIGGER;
            it.effect_number = 6'($urandom_range(3) ? $urandom_range(15) : $urandom_range(63));
            if ($urandom_range(3))
                it.source_tag = 16'($urandom_range(11));
            sel = $urandom_range(9);
            if (sel == 0)
                it.loudness_q10 = 16'd0;
            else if (sel == 1)
                it.loudness_q10 = 16'hFFFF;
            else if (sel < 6)
                it.loudness_q10 = 16'($urandom_range(65535));
            else
                it.loudness_q10 = 16'($urandom_range(1, 2000));
        end
        else
            it.cmd = CMD_TICK;
        return it;
    endfunction

    task automatic test_directed_basics();
        load_frame(16'd0, 16'h7FFF, 16'h8000);
        load_frame(16'hFFFF, 16'h8000, 16'h7FFF);
        load_frame(16'd1, 16'h7FFF, 16'h7FFF);
        define_fx(6'd0, 16'hFFFF, 17'd3);
        define_fx(6'd1, 16'd0, 17'd1);
        trigger_fx(6'd7, 16'd1, 16'd1000, 16'd0);
        trigger_fx(6'd0, 16'd1, 16'd0, 16'd0);
        for (int s = 1; s <= VOICES; s++)
            trigger_fx(6'd0, 16'(s), 16'hFFFF,
                       (s % 3 == 0) ? 16'h8000 : (s % 3 == 1) ? 16'h7FFF : 16'h0000);
        trigger_fx(6'd1, 16'd1, 16'hFFFF, 16'd0);
        trigger_fx(6'd1, 16'd40, 16'd100, 16'd0);
        tick_frames(1);
        define_fx(6'd0, 16'hFFFF, 17'd1);
        tick_frames(1);
        trigger_fx(6'd1, 16'd10, 16'd500, 16'h4000);
        tick_frames(1);
        define_fx(6'd63, 16'd0, 17'd65536);
        define_fx(6'd63, 16'd0, 17'd0);
        settle();
    endtask

    task automatic test_priority_steal();
        define_fx(6'd2, 16'd16, 17'd40);
        for (int s = 0; s < VOICES; s++)
            trigger_fx(6'd2, 16'(100 + s), 16'(800 - 100 * s), 16'($urandom));
        trigger_fx(6'd2, 16'd200, 16'd50, 16'd0);
        trigger_fx(6'd2, 16'd201, 16'd100, 16'd0);
        trigger_fx(6'd2, 16'd202, 16'd900, 16'h8000);
        tick_frames(3);
        trigger_fx(6'd2, 16'd203, 16'd60000, 16'h7FFF);
        tick_frames(45);
        settle();
    endtask

    task automatic test_music_settings();
        set_music(17'd1, 17'hFFFE, 17'd3);
        tick_frames(8);
        set_music(17'h1FFFF, 17'hFFFF, 17'd65536);
        tick_frames(5);
        set_music(17'd1, 17'd0, 17'h1FFFF);
        tick_frames(5);
        set_music(17'd1, 17'd0, 17'd1);
        tick_frames(3);
        set_music(17'd1, 17'd40, 17'd0);
        tick_frames(3);
        set_music(17'd0, 17'd1234, 17'd20);
        tick_frames(3);
        set_music(17'h1FFFE, 17'($urandom), 17'($urandom));
        tick_frames(3);
        set_music(17'd1, 17'd200, 17'd16);
    endtask

    task automatic test_random_traffic(int n, int snd, int rcv);
        snd_pct = snd;
        rcv_pct = rcv;
        for (int k = 0; k < n; k++)
            put_item(rand_item());
    endtask

    task automatic test_output_holdoff();
        snd_pct = 0;
        rcv_pct = 0;
        rcv_hold = 400;
        tick_frames(30);
        settle();
        test_random_traffic(60, 0, 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = REG_MUSIC_ENABLE;
        cfg_data = '0;
        errors = 0;
        frames_checked = 0;
        items_sent = 0;
        ticks_sent = 0;
        steals_seen = 0;
        snd_pct = 0;
        rcv_pct = 0;
        rcv_hold = 0;
        for (int i = 0; i < EFFECTS; i++)
        begin
            fx_start[i] = '0;
            fx_len[i] = '0;
        end
        for (int i = 0; i < VOICES; i++)
        begin
            v_busy[i] = 1'b0;
            v_fx[i] = '0;
            v_pos[i] = '0;
            v_src[i] = '0;
            v_prio[i] = '0;
            v_gain_l[i] = '0;
            v_gain_r[i] = '0;
        end
        mus_pos = '0;
        mus_en = 1'b0;
        mus_base = '0;
        mus_len = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_basics();
        test_priority_steal();
        test_music_settings();
        test_random_traffic(300, 0, 0);
        test_random_traffic(300, 58, 0);
        settle();
        write_reg(REG_MUSIC_BASE, 17'hFFF0);
        write_reg(REG_MUSIC_FRAMES, 17'd37);
        test_random_traffic(300, 0, 58);
        test_random_traffic(300, 34, 34);
        test_output_holdoff();
        settle();

        $display("covered %0d items, %0d ticks, %0d frames checked, %0d steals",
                 items_sent, ticks_sent, frames_checked, steals_seen);
        $display("voice allocation, suppression, stealing, music wrap and stall mixes");
        if (errors == 0 && expected_frames.size() == 0)
            $display("PASS pcm_voice_mixer_with_priority_steal");
        else
            $display("FAIL pcm_voice_mixer_with_priority_steal");
        $finish;
    end

    always @(negedge clk)
    begin
        if (rcv_hold > 0)
        begin
            result_ready <= 1'b0;
            rcv_hold <= rcv_hold - 1;
        end
        else
            result_ready <= ($urandom_range(99) >= rcv_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_frames.size() == 0)
            begin
                $display("%0t unexpected frame: actual %h", $time, result);
                errors++;
            end
            else
            begin
                want = expected_frames.pop_front();
                frames_checked++;
                if (result.left_out !== want.left_out)
                begin
                    $display("%0t left_out mismatch: expected %0d actual %0d",
                             $time, want.left_out, result.left_out);
                    errors++;
                end
                if (result.right_out !== want.right_out)
                begin
                    $display("%0t right_out mismatch: expected %0d actual %0d",
                             $time, want.right_out, result.right_out);
                    errors++;
                end
            end
        end
    end

endmodule

`default_nettype wire
